/* src/sbg_pkg.sv */
// Shared types and constants for the switch bounce generator.
package sbg_pkg;

    // Field widths
    localparam int FREQ_W  = 32;
    localparam int CNT_W   = 7;
    localparam int DIVR_W  = 17;
    localparam int STAT_W  = 2;

    // Bounce count limits and period scale (counts per millisecond)
    localparam logic [CNT_W-1:0]  COUNT_MIN = 7'd10;
    localparam logic [CNT_W-1:0]  COUNT_MAX = 7'd99;
    localparam logic [DIVR_W-1:0] KHZ_SCALE = 17'd1000;

    // Divider iteration count
    localparam int DIV_STEPS = FREQ_W;
    localparam int DSTEP_W   = $clog2(DIV_STEPS);

    // Opcodes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_BOUNCE = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_NONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_TOGGLE = 2'd1;
    localparam logic [STAT_W-1:0] ST_DONE   = 2'd2;

    // Control states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_WALK = 3'b100
    } state_t;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [FREQ_W-1:0] dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [FREQ_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* src/sbg_div.sv */
// Radix-2 restoring divider for the toggle period, one quotient bit per cycle.
module sbg_div (
    input  logic            clk,
    input  logic            rst_n,
    input  sbg_pkg::div_req_t req,
    output sbg_pkg::div_rsp_t rsp
);
    import sbg_pkg::*;

    logic [DIVR_W-1:0]  rem_reg;
    logic [FREQ_W-1:0]  quo_reg;
    logic [DIVR_W-1:0]  dvs_reg;
    logic [DSTEP_W-1:0] step_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [DIVR_W:0]    shifted;
    logic               ge;
    logic [DIVR_W:0]    diff;

    // One shift-subtract step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[FREQ_W-1]};
        ge      = (shifted >= {1'b0, dvs_reg});
        diff    = shifted - {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= '0;
                quo_reg  <= req.dividend;
                dvs_reg  <= req.divisor;
                step_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                // remainder stays below the divisor, so the top bit drops
                rem_reg  <= ge ? diff[DIVR_W-1:0] : shifted[DIVR_W-1:0];
                quo_reg  <= {quo_reg[FREQ_W-2:0], ge};
                step_reg <= step_reg + 1'b1;
                if (step_reg == DSTEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* src/sbg_cnt_mem.sv */
// Switch counter memory: one write and one registered read port, per-entry valid bits.
module sbg_cnt_mem #(
    parameter int SWITCHES = 8,
    parameter int IW       = 3
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      we,
    input  logic [IW-1:0]             waddr,
    input  logic [sbg_pkg::CNT_W-1:0] wdata,
    input  logic                      re,
    input  logic [IW-1:0]             raddr,
    output logic [sbg_pkg::CNT_W-1:0] rdata
);
    import sbg_pkg::*;

    logic [CNT_W-1:0]    mem [SWITCHES];
    logic [SWITCHES-1:0] valid_reg;
    logic [CNT_W-1:0]    rdata_reg;
    logic                rvalid_reg;

    // Storage and read data
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // Written-entry tracking; unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (we)
                valid_reg[waddr] <= 1'b1;
            if (re)
                rvalid_reg <= valid_reg[raddr];
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

/* src/sbg_out_q.sv */
// Two-entry status queue between the control logic and the result channel.
module sbg_out_q (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [sbg_pkg::STAT_W-1:0] push_data,
    output logic                       full,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [sbg_pkg::STAT_W-1:0] status
);
    import sbg_pkg::*;

    logic [STAT_W-1:0] slot_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign status    = slot_reg[rd_ptr_reg];

    // Slot data
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

/* src/switch_bounce_generator.sv */
// Switch bounce generator top level: control sequencer, config register, period state.
// Timing: a tick or request answers at its accept edge; a tick that ends the
// period walks the counter memory; the first bounce request after reset waits for the
// 32-step period divider. Otherwise one item per cycle while the status queue has room.
// Reset: asynchronous, active low; counters read as zero through per-entry valid bits,
// so there is no clearing pass.
module switch_bounce_generator #(
    parameter int SWITCHES = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       opcode,
    input  logic [5:0]                 switch_index,
    input  logic [sbg_pkg::CNT_W-1:0]  bounce_count,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [sbg_pkg::STAT_W-1:0] status
);
    import sbg_pkg::*;

    localparam int IW = (SWITCHES > 1) ? $clog2(SWITCHES) : 1;
    localparam int CW = $clog2(SWITCHES + 1);

    state_t            state_reg, state_next;
    logic              armed_reg, armed_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [FREQ_W-1:0] period_left_reg, period_left_next;
    logic [FREQ_W-1:0] period_reload_reg, period_reload_next;
    logic [FREQ_W-1:0] freq_reg;
    logic [IW-1:0]     sw_reg, sw_next;
    logic [CW-1:0]     rd_cnt_reg, rd_cnt_next;
    logic              wb_valid_reg, wb_valid_next;
    logic [IW-1:0]     wb_addr_reg, wb_addr_next;
    logic              fin_reg, fin_next;

    logic              in_fire;
    logic              sw_ok;
    logic [CNT_W-1:0]  sat_count;
    logic              hit;
    logic              q_full;
    logic              push;
    logic [STAT_W-1:0] push_status;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [CNT_W-1:0]  mem_wdata;
    logic              mem_re;
    logic [IW-1:0]     mem_raddr;
    logic [CNT_W-1:0]  mem_rdata;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // Config port: single register, decoded wherever paddr[2] is low (addresses 0 to 3)
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? freq_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            freq_reg <= 32'd16000000;
        else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
            freq_reg <= pwdata;
    end

    // Request decode helpers
    assign in_ready = (state_reg == S_IDLE) && !q_full;
    assign in_fire  = in_valid && in_ready;
    assign sw_ok    = ({1'b0, switch_index} < 7'(SWITCHES));

    always_comb
    begin
        if (bounce_count < COUNT_MIN)
            sat_count = COUNT_MIN;
        else if (bounce_count > COUNT_MAX)
            sat_count = COUNT_MAX;
        else
            sat_count = bounce_count;
    end

    // Sequencer
    always_comb
    begin
        state_next         = state_reg;
        armed_next         = armed_reg;
        held_next          = held_reg;
        period_left_next   = period_left_reg;
        period_reload_next = period_reload_reg;
        sw_next            = sw_reg;
        rd_cnt_next        = rd_cnt_reg;
        wb_valid_next      = wb_valid_reg;
        wb_addr_next       = wb_addr_reg;
        fin_next           = fin_reg;
        push               = 1'b0;
        push_status        = ST_NONE;
        mem_we             = 1'b0;
        mem_waddr          = sw_reg;
        mem_wdata          = held_reg;
        mem_re             = 1'b0;
        mem_raddr          = rd_cnt_reg[IW-1:0];
        div_req            = '0;
        hit                = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (opcode == OP_BOUNCE)
                    begin
                        if (!sw_ok)
                            push = 1'b1;
                        else if (held_reg == '0)
                        begin
                            // first request: latch count, derive period
                            held_next        = sat_count;
                            sw_next          = switch_index[IW-1:0];
                            div_req.start    = 1'b1;
                            div_req.dividend = freq_reg;
                            div_req.divisor  = DIVR_W'(17'(sat_count) * KHZ_SCALE);
                            state_next       = S_DIV;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = switch_index[IW-1:0];
                            mem_wdata  = held_reg;
                            armed_next = 1'b1;
                            push       = 1'b1;
                        end
                    end
                    else if (armed_reg && (period_left_reg < 32'd2))
                    begin
                        // period over: reload and walk the counters
                        period_left_next = period_reload_reg;
                        rd_cnt_next      = '0;
                        wb_valid_next    = 1'b0;
                        fin_next         = 1'b0;
                        state_next       = S_WALK;
                    end
                    else
                    begin
                        if (armed_reg)
                            period_left_next = period_left_reg - 32'd1;
                        push = 1'b1;
                    end
                end
            end

            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    period_reload_next = (div_rsp.quotient == '0) ? 32'd1 : div_rsp.quotient;
                    period_left_next   = (div_rsp.quotient == '0) ? 32'd1 : div_rsp.quotient;
                    mem_we             = 1'b1;
                    armed_next         = 1'b1;
                    push               = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            S_WALK:
            begin
                // read side: one entry per cycle
                if (rd_cnt_reg != CW'(SWITCHES))
                begin
                    mem_re        = 1'b1;
                    wb_addr_next  = rd_cnt_reg[IW-1:0];
                    wb_valid_next = 1'b1;
                    rd_cnt_next   = rd_cnt_reg + 1'b1;
                end
                else
                    wb_valid_next = 1'b0;

                // write-back side: decrement nonzero counters
                if (wb_valid_reg && (mem_rdata != '0))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wb_addr_reg;
                    mem_wdata = mem_rdata - 1'b1;
                    hit       = (mem_rdata == 7'd1);
                    if (hit)
                        fin_next = 1'b1;
                end

                // last write-back closes the expiry
                if (wb_valid_reg && (rd_cnt_reg == CW'(SWITCHES)))
                begin
                    push = 1'b1;
                    if (fin_reg || hit)
                    begin
                        push_status = ST_DONE;
                        armed_next  = 1'b0;
                    end
                    else
                        push_status = ST_TOGGLE;
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            armed_reg         <= 1'b0;
            held_reg          <= '0;
            period_left_reg   <= '0;
            period_reload_reg <= '0;
            sw_reg            <= '0;
            rd_cnt_reg        <= '0;
            wb_valid_reg      <= 1'b0;
            wb_addr_reg       <= '0;
            fin_reg           <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            armed_reg         <= armed_next;
            held_reg          <= held_next;
            period_left_reg   <= period_left_next;
            period_reload_reg <= period_reload_next;
            sw_reg            <= sw_next;
            rd_cnt_reg        <= rd_cnt_next;
            wb_valid_reg      <= wb_valid_next;
            wb_addr_reg       <= wb_addr_next;
            fin_reg           <= fin_next;
        end
    end

    // Units
    sbg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    sbg_cnt_mem #(
        .SWITCHES (SWITCHES),
        .IW       (IW)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    sbg_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_status),
        .full      (q_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status)
    );

endmodule
